// ===== rtl/core/binary_search_table_defines.svh =====
// Assertion macros shared by the binary search table RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef BINARY_SEARCH_TABLE_DEFINES_SVH
`define BINARY_SEARCH_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bst_pkg.sv =====
// Types and fixed constants of the binary search table.
// No dependencies; imported by bst_step and binary_search_table.
package bst_pkg;

	localparam int IDX_W = 10;  // index fields on the stream
	localparam int BND_W = 12;  // signed working bounds, hold -1 .. 1024
	localparam int RES_W = 11;  // found_index field
	localparam logic [RES_W-1:0] NOT_FOUND = '1;  // -1

	typedef enum logic {
		FUNC_WRITE  = 1'b0,
		FUNC_SEARCH = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_CMP,
		ST_DONE
	} state_t;

	// Result of one pass through the compare/narrow unit
	typedef struct packed {
		logic                    hit;
		logic                    empty;
		logic signed [BND_W-1:0] lo;
		logic signed [BND_W-1:0] hi;
		logic [IDX_W-1:0]        mid;
	} step_t;

endpackage

// ===== rtl/core/bst_table.sv =====
// Table storage: one write port, one read port with registered data.
// Depends on nothing; instantiated by binary_search_table.
module bst_table #(
	parameter int DEPTH = 1024,
	parameter int KW    = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [KW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [KW-1:0] rdata
);

	logic [KW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/bst_step.sv =====
// Shared compare/narrow unit: compares key against a probe, updates the
// bounds, and gives the next midpoint and the empty flag. Uses bst_pkg.
module bst_step #(
	parameter int KW = 32
) (
	input  logic                            advance,
	input  logic [KW-1:0]                   key,
	input  logic [KW-1:0]                   probe,
	input  logic signed [bst_pkg::BND_W-1:0] lo,
	input  logic signed [bst_pkg::BND_W-1:0] hi,
	input  logic [bst_pkg::IDX_W-1:0]       mid_in,
	output bst_pkg::step_t                  res
);
	import bst_pkg::*;

	logic                    eq;
	logic                    lt;
	logic signed [BND_W-1:0] mid_ext;
	logic signed [BND_W-1:0] lo_sel;
	logic signed [BND_W-1:0] hi_sel;
	logic signed [BND_W-1:0] sum;

	assign eq      = (key == probe);
	assign lt      = ($signed(key) < $signed(probe));
	assign mid_ext = $signed({{(BND_W-IDX_W){1'b0}}, mid_in});

	always_comb begin
		lo_sel  = lo;
		hi_sel  = hi;
		res.hit = 1'b0;
		if (advance) begin
			if (eq) begin
				res.hit = 1'b1;
			end else if (lt) begin
				hi_sel = mid_ext - 12'sd1;
			end else begin
				lo_sel = mid_ext + 12'sd1;
			end
		end
		// bounds are non-negative whenever the range is non-empty
		sum       = lo_sel + hi_sel;
		res.empty = (hi_sel < lo_sel);
		res.lo    = lo_sel;
		res.hi    = hi_sel;
		res.mid   = sum[IDX_W:1];
	end

endmodule

// ===== rtl/core/binary_search_table.sv =====
// Top level of the binary search table: stream ports, sequencer, output register.
// Depends on bst_pkg, bst_table, bst_step and binary_search_table_defines.svh.
//
// Usage:
//  - Input stream s_axis: tuser selects the transfer kind (0 = write an entry,
//    1 = search). A write stores item_value at write_index (indexes at or past
//    TABLE_DEPTH are dropped) and returns nothing. A search brings a key and an
//    inclusive range [low_bound, high_bound] and returns one result.
//  - Output stream m_axis: found_index, the first matching index met while
//    bisecting, or -1 when the range runs empty. high_bound saturates to
//    TABLE_DEPTH-1; a negative high_bound gives -1 at once.
//  - Sequence: a write is taken in IDLE and the block stays ready for the next item.
//    A search runs a setup state (LOOK), one CMP state per table probe (the read
//    port of the table memory is used once per cycle in CMP, about log2(range)+1
//    probes, 11 for a 1024-entry range) and a DONE state that loads the output
//    register. s_axis_tready is low while a search runs.
//  - Stall: the result waits in the output register; a new item is accepted
//    meanwhile, but a later search holds before loading its result until the
//    register is free.
//  - Reset clears the sequencer and output valid; table contents are undefined
//    until written, and searches must only probe entries written before.
`include "binary_search_table_defines.svh"

module binary_search_table #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_WIDTH   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [9:0] write_index, [41:10] item_value, [51:42] low_bound,
	// [62:52] high_bound, [63] zero
	input  logic [63:0] s_axis_tdata,
	// [0] func
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [10:0] found_index, [15:11] zero
	output logic [15:0] m_axis_tdata
);
	import bst_pkg::*;

	localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int HI_MAX = (TABLE_DEPTH - 1 < 1023) ? (TABLE_DEPTH - 1) : 1023;

	// input field unpacking
	func_t             func_in;
	logic [IDX_W-1:0]  write_index;
	logic [31:0]       item_value;
	logic [IDX_W-1:0]  low_bound;
	logic [RES_W-1:0]  high_bound;

	assign func_in     = func_t'(s_axis_tuser);
	assign write_index = s_axis_tdata[9:0];
	assign item_value  = s_axis_tdata[41:10];
	assign low_bound   = s_axis_tdata[51:42];
	assign high_bound  = s_axis_tdata[62:52];

	// sequencer and datapath registers
	state_t                  state_q;
	state_t                  state_nxt;
	logic [KEY_WIDTH-1:0]    key_q;
	logic signed [BND_W-1:0] lo_q;
	logic signed [BND_W-1:0] hi_q;
	logic [IDX_W-1:0]        mid_q;
	logic [RES_W-1:0]        res_q;
	logic                    out_valid_q;
	logic [RES_W-1:0]        out_data_q;

	// control
	logic                    in_xfer;
	logic                    start_search;
	logic                    tbl_we;
	logic [AW-1:0]           tbl_raddr;
	logic [KEY_WIDTH-1:0]    tbl_rdata;
	logic                    slot_free;
	logic                    load_out;
	logic                    step_adv;
	step_t                   step_res;
	logic signed [BND_W-1:0] lo_init;
	logic signed [BND_W-1:0] hi_init;

	assign in_xfer      = s_axis_tvalid && s_axis_tready;
	assign start_search = in_xfer && (func_in == FUNC_SEARCH);
	assign slot_free    = !out_valid_q || m_axis_tready;

	// Bounds of a new search: low extended, high saturated to the table;
	// a negative high bound becomes -1 so the range reads empty.
	assign lo_init = $signed({{(BND_W-IDX_W){1'b0}}, low_bound});
	always_comb begin
		if (high_bound[RES_W-1]) begin
			hi_init = -12'sd1;
		end else if (int'(high_bound) > HI_MAX) begin
			hi_init = BND_W'(HI_MAX);
		end else begin
			hi_init = $signed({1'b0, high_bound});
		end
	end

	bst_table #(
		.DEPTH (TABLE_DEPTH),
		.KW    (KEY_WIDTH),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (AW'(write_index)),
		.wdata (KEY_WIDTH'(item_value)),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	// In LOOK the unit only sizes up the fresh range; in CMP it also narrows it.
	bst_step #(
		.KW (KEY_WIDTH)
	) u_step (
		.advance (step_adv),
		.key     (key_q),
		.probe   (tbl_rdata),
		.lo      (lo_q),
		.hi      (hi_q),
		.mid_in  (mid_q),
		.res     (step_res)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start_search) begin
					state_nxt = ST_LOOK;
				end
			end
			ST_LOOK: begin
				state_nxt = step_res.empty ? ST_DONE : ST_CMP;
			end
			ST_CMP: begin
				if (step_res.hit || step_res.empty) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		tbl_we        = 1'b0;
		step_adv      = 1'b0;
		load_out      = 1'b0;
		tbl_raddr     = AW'(step_res.mid);
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				tbl_we        = in_xfer && (func_in == FUNC_WRITE)
				                && (int'(write_index) < TABLE_DEPTH);
			end
			ST_LOOK: begin
				step_adv = 1'b0;
			end
			ST_CMP: begin
				step_adv = 1'b1;
			end
			ST_DONE: begin
				load_out = slot_free;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (start_search) begin
			key_q <= KEY_WIDTH'(item_value);
			lo_q  <= lo_init;
			hi_q  <= hi_init;
		end
		if (state_q == ST_LOOK) begin
			mid_q <= step_res.mid;
			if (step_res.empty) begin
				res_q <= NOT_FOUND;
			end
		end
		if (state_q == ST_CMP) begin
			if (step_res.hit) begin
				res_q <= {1'b0, mid_q};
			end else begin
				lo_q  <= step_res.lo;
				hi_q  <= step_res.hi;
				mid_q <= step_res.mid;
				if (step_res.empty) begin
					res_q <= NOT_FOUND;
				end
			end
		end
		if (load_out) begin
			out_data_q <= res_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(16-RES_W){1'b0}}, out_data_q};

	// checks
	`BST_ASSERT_NOW(a_probe_in_range, clk, arst_n, state_q == ST_CMP,
		($signed({2'b00, mid_q}) >= lo_q) && ($signed({2'b00, mid_q}) <= hi_q),
		"probe index outside the search range")
	`BST_ASSERT_NEXT(a_search_starts, clk, arst_n, start_search,
		state_q == ST_LOOK, "accepted search did not start")
	`BST_ASSERT_NOW(a_result_legal, clk, arst_n, out_valid_q,
		(out_data_q == NOT_FOUND) || (int'(out_data_q) < TABLE_DEPTH),
		"result index beyond the table")

endmodule

// ===== tb/sv/binary_search_table_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for binary_search_table: table fills, bisection searches, empty ranges,
// unsorted regions and stream back-pressure, checked against a behavioral bisection model.
// Depends on bst_pkg and the binary_search_table RTL.
module binary_search_table_tb;
	import bst_pkg::*;

	localparam int DEPTH        = 1024;
	localparam int TBL_FILL     = 256;   // entries written, the top end of the table
	localparam int TBL_BASE     = DEPTH - TBL_FILL;
	localparam int UNSORTED_AT  = TBL_BASE + 200;
	localparam int HOLD_CYCLES  = 300;   // long receiver hold-off in the pressure test
	localparam int STALL_LIMIT  = 5000;  // cycles without any transfer before giving up
	localparam int PHASE_ITEMS  = 25;    // random items per idle mix
	localparam int SETTLE       = 16;    // quiet cycles after the last result
	localparam longint KEY_MIN  = -(longint'(1) << 31);
	localparam longint KEY_MAX  = (longint'(1) << 31) - 1;
	localparam logic [IDX_W-1:0]        BASE_LO = IDX_W'(TBL_BASE);
	localparam logic signed [RES_W-1:0] TOP_HI  = RES_W'(DEPTH - 1);

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// [9:0] write_index, [41:10] item_value, [51:42] low_bound, [62:52] high_bound, [63] zero
	logic [63:0] s_axis_tdata  = '0;
	// [0] func
	logic        s_axis_tuser  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [10:0] found_index, [15:11] zero
	logic [15:0] m_axis_tdata;

	// Shadow copy of the table and the answers still owed by the block
	logic signed [31:0]      sorted_keys [DEPTH];
	logic signed [RES_W-1:0] owed_found [$];

	int idle_pct   = 0;   // sender gap probability, percent
	int stall_pct  = 0;   // receiver stall probability, percent
	int hold_token = 0;   // bumped by the stimulus to request a long hold-off
	int hold_seen  = 0;
	int hold_left  = 0;
	int mismatches = 0;
	int no_xfer_cycles = 0;
	int n_writes = 0, n_searches = 0, n_hits = 0, n_misses = 0;

	binary_search_table uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Bisection over the shadow table: first hit in probe order, or -1.
	// A negative high bound is empty; a high bound past the table saturates.
	function automatic logic signed [RES_W-1:0] bisect_lookup(input logic signed [31:0] key,
			input logic [IDX_W-1:0] lo_b, input logic signed [RES_W-1:0] hi_b);
		int lo, hi, mid;
		if (hi_b < 0)
			return NOT_FOUND;
		lo = int'(lo_b);
		hi = int'(hi_b);
		if (hi > DEPTH - 1)
			hi = DEPTH - 1;
		while (hi >= lo) begin
			mid = (lo + hi) / 2;
			if (key == sorted_keys[IDX_W'(mid)])
				return RES_W'(mid);
			if (key < sorted_keys[IDX_W'(mid)])
				hi = mid - 1;
			else
				lo = mid + 1;
		end
		return NOT_FOUND;
	endfunction

	// Offer one item, with a random gap first, and account for it once the transfer happens.
	// tvalid is left high so back-to-back items never drop it within one step.
	task automatic send_item(input func_t func, input logic [IDX_W-1:0] widx,
			input logic signed [31:0] value, input logic [IDX_W-1:0] lo_b,
			input logic signed [RES_W-1:0] hi_b);
		logic signed [RES_W-1:0] found;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= func;
		s_axis_tdata  <= {1'b0, hi_b, lo_b, value, widx};
		do @(posedge clk); while (!s_axis_tready);
		if (func == FUNC_WRITE) begin
			sorted_keys[widx] = value;
			n_writes++;
		end else begin
			found = bisect_lookup(value, lo_b, hi_b);
			owed_found.push_back(found);
			n_searches++;
			if (found == NOT_FOUND)
				n_misses++;
			else
				n_hits++;
		end
	endtask

	// Stop offering and hold off until every owed answer is back, plus a settle time
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (owed_found.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Random search: mostly narrow ranges inside the filled region with keys drawn from
	// them, some wide ranges, some empty or negative upper bounds, some likely absent keys.
	task automatic random_search();
		logic [IDX_W-1:0]        lo_b;
		logic signed [RES_W-1:0] hi_b;
		logic signed [31:0]      key;
		int lo_i, top, pick;
		pick = $urandom_range(99);
		lo_i = $urandom_range(DEPTH - 1, TBL_BASE);
		if (pick < 60) begin
			top = lo_i + $urandom_range(31);
			if (top > DEPTH - 1)
				top = DEPTH - 1;
		end else if (pick < 85) begin
			if ($urandom_range(1))
				lo_i = TBL_BASE + $urandom_range(15);
			top = $urandom_range(DEPTH - 1, lo_i);
		end else if (pick < 93) begin
			// high below low, low anywhere in the table
			lo_i = $urandom_range(DEPTH - 1, 1);
			top  = $urandom_range(lo_i - 1);
		end else begin
			// negative high bound
			lo_i = $urandom_range(DEPTH - 1);
			top  = -1 - $urandom_range(DEPTH - 1);
		end
		lo_b = IDX_W'(lo_i);
		hi_b = RES_W'(top);
		pick = $urandom_range(99);
		if (top >= lo_i && pick < 75)
			key = sorted_keys[IDX_W'($urandom_range(top, lo_i))];
		else if (top >= lo_i && pick < 85)
			key = sorted_keys[IDX_W'($urandom_range(top, lo_i))]
			      + (($urandom_range(1)) ? 1 : -1);
		else
			key = $urandom;
		send_item(FUNC_SEARCH, IDX_W'($urandom), key, lo_b, hi_b);
	endtask

	// Before any write: only searches whose range is empty, so no entry is probed
	task automatic test_empty_ranges();
		send_item(FUNC_SEARCH, '0, $urandom, 10'd0, -11'sd1);
		send_item(FUNC_SEARCH, '1, $urandom, 10'd0, -11'sd1024);
		send_item(FUNC_SEARCH, '0, $urandom, 10'd5, 11'sd4);
		send_item(FUNC_SEARCH, '0, $urandom, 10'd1023, 11'sd0);
		send_item(FUNC_SEARCH, '0, $urandom, 10'd1023, -11'sd512);
	endtask

	// Ascending fill of the top of the table from the most negative to the most positive
	// key, with random duplicates and one run of equal keys 32 entries into the region.
	task automatic test_fill_table();
		longint v;
		v = KEY_MIN;
		for (int i = 0; i < TBL_FILL; i++) begin
			if (i == TBL_FILL - 1)
				v = KEY_MAX;
			else if (i > 0 && !(i >= 32 && i < 48) && $urandom_range(5) != 0)
				v += $urandom_range(16_000_000);
			if (v > KEY_MAX)
				v = KEY_MAX;
			send_item(FUNC_WRITE, IDX_W'(TBL_BASE + i), v[31:0], IDX_W'($urandom),
				RES_W'($urandom));
		end
	endtask

	task automatic test_directed_searches();
		// Extreme keys over the full region, a key inside the duplicate run and a mid-region key
		send_item(FUNC_SEARCH, '0, sorted_keys[TBL_BASE], BASE_LO, TOP_HI);
		send_item(FUNC_SEARCH, '0, sorted_keys[DEPTH-1], BASE_LO, TOP_HI);
		send_item(FUNC_SEARCH, '0, sorted_keys[TBL_BASE+40], BASE_LO, TOP_HI);
		send_item(FUNC_SEARCH, '0, sorted_keys[TBL_BASE+100], BASE_LO, TOP_HI);
		// Likely absent key, and a present key outside the range
		send_item(FUNC_SEARCH, '0, sorted_keys[TBL_BASE+150] + 1, BASE_LO, TOP_HI);
		send_item(FUNC_SEARCH, '0, sorted_keys[DEPTH-10], BASE_LO, RES_W'(TBL_BASE + 100));
		// Single-entry ranges at both ends
		send_item(FUNC_SEARCH, '0, sorted_keys[DEPTH-1], 10'd1023, 11'sd1023);
		send_item(FUNC_SEARCH, '0, sorted_keys[TBL_BASE] + 1, BASE_LO, RES_W'(TBL_BASE));
		// Rewrite the ends with the extremes, then search just written values
		send_item(FUNC_WRITE, BASE_LO, KEY_MIN[31:0], '0, '0);
		send_item(FUNC_WRITE, 10'd1023, KEY_MAX[31:0], '1, '1);
		send_item(FUNC_WRITE, IDX_W'(TBL_BASE + 50), sorted_keys[TBL_BASE+49], '0, '0);
		send_item(FUNC_SEARCH, '1, sorted_keys[TBL_BASE+50], IDX_W'(TBL_BASE + 20),
			RES_W'(TBL_BASE + 120));
		send_item(FUNC_SEARCH, '0, KEY_MIN[31:0], BASE_LO, TOP_HI);
	endtask

	// Out-of-order region: the probe path follows the comparisons whatever the order
	task automatic test_unsorted_region();
		send_item(FUNC_WRITE, IDX_W'(UNSORTED_AT), 32'sd900, '0, '0);
		send_item(FUNC_WRITE, IDX_W'(UNSORTED_AT + 1), -32'sd7, '0, '0);
		send_item(FUNC_WRITE, IDX_W'(UNSORTED_AT + 2), 32'sd5000, '0, '0);
		send_item(FUNC_WRITE, IDX_W'(UNSORTED_AT + 3), -32'sd300, '0, '0);
		send_item(FUNC_SEARCH, '0, -32'sd7, IDX_W'(UNSORTED_AT), RES_W'(UNSORTED_AT + 3));
		send_item(FUNC_SEARCH, '0, -32'sd300, IDX_W'(UNSORTED_AT), RES_W'(UNSORTED_AT + 3));
		send_item(FUNC_SEARCH, '0, 32'sd900, IDX_W'(UNSORTED_AT), RES_W'(UNSORTED_AT + 3));
	endtask

	// One idle mix of random traffic: mostly searches, writes that mostly keep the order
	task automatic test_random_phase(input int sender_gap, input int receiver_stall);
		int               idx;
		longint           lo_v, hi_v;
		longint unsigned  r;
		logic signed [31:0] value;
		idle_pct = sender_gap;
		stall_pct <= receiver_stall;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if ($urandom_range(49) == 0)
				wait_drained();
			if ($urandom_range(99) < 70) begin
				random_search();
			end else begin
				idx = $urandom_range(DEPTH - 1, TBL_BASE);
				lo_v = (idx > TBL_BASE) ? longint'(sorted_keys[IDX_W'(idx - 1)]) : KEY_MIN;
				hi_v = (idx < DEPTH - 1) ? longint'(sorted_keys[IDX_W'(idx + 1)]) : KEY_MAX;
				if ($urandom_range(99) < 85 && hi_v >= lo_v) begin
					r = {$urandom, $urandom};
					r = r % longint'(hi_v - lo_v + 1);
					value = 32'(lo_v + r);
				end else begin
					value = $urandom;  // breaks the order now and then
				end
				send_item(FUNC_WRITE, idx[IDX_W-1:0], value, IDX_W'($urandom),
					RES_W'($urandom));
			end
		end
		wait_drained();
	endtask

	// Receiver holds off for a long stretch while searches keep coming, so the
	// output register fills and the block stalls its input
	task automatic test_output_backpressure();
		idle_pct = 0;
		stall_pct <= 0;
		hold_token <= hold_token + 1;
		for (int n = 0; n < 24; n++)
			random_search();
		wait_drained();
	endtask

	// Result checker and receiver readiness
	always @(posedge clk) begin
		logic signed [RES_W-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (owed_found.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: found_index %0d arrived with no search pending",
						$signed(m_axis_tdata[RES_W-1:0]));
			end else begin
				want = owed_found.pop_front();
				if (m_axis_tdata[RES_W-1:0] !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: found_index %0d, expected %0d",
							$signed(m_axis_tdata[RES_W-1:0]), want);
				end
			end
		end
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: any transfer on either side counts as progress
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			no_xfer_cycles <= 0;
		end else if (no_xfer_cycles >= STALL_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles, %0d results owed",
				no_xfer_cycles, owed_found.size());
			$display("Test completed with failures");
			$finish;
		end else begin
			no_xfer_cycles <= no_xfer_cycles + 1;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_ranges();
		test_fill_table();
		test_directed_searches();
		test_unsorted_region();
		wait_drained();
		test_random_phase(0, 0);
		test_random_phase(52, 0);
		test_random_phase(0, 52);
		test_random_phase(23, 23);
		test_output_backpressure();
		$display("Ran %0d table writes and %0d searches (%0d hits, %0d misses)",
			n_writes, n_searches, n_hits, n_misses);
		$display("over four idle mixes and a %0d-cycle output hold-off; %0d mismatches",
			HOLD_CYCLES, mismatches);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
